// ===== sv/mcam_pkg.sv =====
package mcam_pkg;

  localparam int FIELD_BITS = 32;

  localparam logic [2:0] OP_RD_FIRST  = 3'd0;
  localparam logic [2:0] OP_RD_SECOND = 3'd1;
  localparam logic [2:0] OP_RD_VALUE  = 3'd2;
  localparam logic [2:0] OP_WR_FIRST  = 3'd3;
  localparam logic [2:0] OP_WR_SECOND = 3'd4;
  localparam logic [2:0] OP_WR_VALUE  = 3'd5;
  localparam logic [2:0] OP_LOOKUP    = 3'd6;

  typedef struct packed {
    logic [2:0]            op;
    logic [31:0]           row_base;
    logic signed [11:0]    row_offset;
    logic [31:0]           key_first;
    logic [31:0]           key_second;
    logic [31:0]           store_value;
    logic [4:0]            ignore_bits;
  } mcam_in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        hit;
    logic        index_error;
  } mcam_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_SCAN
  } mcam_state_t;

  typedef enum logic [1:0] {
    RD_ROW,
    RD_FIRST,
    RD_NEXT
  } mcam_rd_src_t;

  typedef enum logic [1:0] {
    RES_PLAIN,
    RES_READ,
    RES_HIT
  } mcam_res_t;

  typedef struct packed {
    logic         clr_en;
    logic         capture;
    logic         wr_en;
    logic         rd_en;
    mcam_rd_src_t rd_src;
    logic         load_out;
    mcam_res_t    res_sel;
  } mcam_cmd_t;

  typedef struct packed {
    logic is_lookup;
    logic is_read;
    logic in_range;
    logic match;
    logic scan_last;
    logic clr_last;
    logic out_free;
  } mcam_stat_t;

endpackage

// ===== sv/mcam_ctrl.sv =====
module mcam_ctrl
  import mcam_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  mcam_stat_t stat,
  output mcam_cmd_t  cmd
);

  mcam_state_t state_r;
  mcam_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (stat.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        priority if (stat.is_lookup) begin
          state_nxt = ST_SCAN;
        end else if (stat.is_read && stat.in_range) begin
          state_nxt = ST_READ;
        end else begin
          if (stat.out_free) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_READ: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if ((stat.match || stat.scan_last) && stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd.clr_en     = 1'b0;
    cmd.capture    = 1'b0;
    cmd.wr_en      = 1'b0;
    cmd.rd_en      = 1'b0;
    cmd.rd_src     = RD_ROW;
    cmd.load_out   = 1'b0;
    cmd.res_sel    = RES_PLAIN;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
      end
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_DECODE: begin
        priority if (stat.is_lookup) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = RD_FIRST;
        end else if (stat.is_read && stat.in_range) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = RD_ROW;
        end else begin
          cmd.wr_en    = stat.out_free;
          cmd.load_out = stat.out_free;
          cmd.res_sel  = RES_PLAIN;
        end
      end
      ST_READ: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          cmd.res_sel  = RES_READ;
        end
      end
      ST_SCAN: begin
        priority if (stat.match) begin
          cmd.load_out = stat.out_free;
          cmd.res_sel  = RES_HIT;
        end else if (stat.scan_last) begin
          cmd.load_out = stat.out_free;
          cmd.res_sel  = RES_PLAIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = RD_NEXT;
        end
      end
      default: begin
        cmd.clr_en = 1'b0;
      end
    endcase
  end

endmodule

// ===== sv/mcam_dp.sv =====
module mcam_dp
  import mcam_pkg::*;
#(
  parameter int ROWS      = 64,
  parameter int WORD_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  mcam_in_t   in_data,
  input  mcam_cmd_t  cmd,
  output mcam_stat_t stat,
  output logic       out_valid,
  input  logic       out_ready,
  output mcam_out_t  out_data
);

  localparam int AW = $clog2(ROWS);
  localparam logic [AW-1:0] LAST_ROW = AW'(ROWS - 1);
  localparam logic [6:0] WB7 = 7'(WORD_BITS);

  logic [WORD_BITS-1:0] first_mem_r  [ROWS];
  logic [WORD_BITS-1:0] second_mem_r [ROWS];
  logic [WORD_BITS-1:0] value_mem_r  [ROWS];

  mcam_in_t             item_r;
  logic [AW-1:0]        clr_r;
  logic [AW-1:0]        addr_q_r;
  logic [WORD_BITS-1:0] first_q_r;
  logic [WORD_BITS-1:0] second_q_r;
  logic [WORD_BITS-1:0] value_q_r;
  logic                 out_valid_r;
  mcam_out_t            out_data_r;

  logic signed [33:0]   row_sum;
  logic                 in_range;
  logic [AW-1:0]        row_idx;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;
  logic                 we_first;
  logic                 we_second;
  logic                 we_value;
  logic [WORD_BITS-1:0] k0w;
  logic [WORD_BITS-1:0] k1w;
  logic [WORD_BITS-1:0] svw;
  logic [WORD_BITS-1:0] keep;
  logic [WORD_BITS-1:0] hit_word;
  logic [WORD_BITS-1:0] read_word;
  logic                 match;
  logic                 is_access;
  mcam_out_t            result;

  assign row_sum  = $signed({2'b00, item_r.row_base}) + 34'(item_r.row_offset);
  assign in_range = !row_sum[33] && (row_sum[32:0] < 33'(ROWS));
  assign row_idx  = row_sum[AW-1:0];

  assign k0w = WORD_BITS'(item_r.key_first);
  assign k1w = WORD_BITS'(item_r.key_second);
  assign svw = WORD_BITS'(item_r.store_value);

  assign is_access = (item_r.op <= OP_WR_VALUE);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_en) begin
      clr_r <= clr_r + AW'(1);
    end
  end

  always_comb begin
    we_first  = 1'b0;
    we_second = 1'b0;
    we_value  = 1'b0;
    wr_addr   = row_idx;
    if (cmd.clr_en) begin
      we_first  = 1'b1;
      we_second = 1'b1;
      we_value  = 1'b1;
      wr_addr   = clr_r;
    end else if (cmd.wr_en && in_range) begin
      we_first  = (item_r.op == OP_WR_FIRST);
      we_second = (item_r.op == OP_WR_SECOND);
      we_value  = (item_r.op == OP_WR_VALUE);
    end
  end

  always_ff @(posedge clk) begin
    if (we_first) begin
      first_mem_r[wr_addr] <= cmd.clr_en ? '0 : k0w;
    end
  end

  always_ff @(posedge clk) begin
    if (we_second) begin
      second_mem_r[wr_addr] <= cmd.clr_en ? '0 : k1w;
    end
  end

  always_ff @(posedge clk) begin
    if (we_value) begin
      value_mem_r[wr_addr] <= cmd.clr_en ? '0 : svw;
    end
  end

  always_comb begin
    unique case (cmd.rd_src)
      RD_ROW:   rd_addr = row_idx;
      RD_FIRST: rd_addr = '0;
      RD_NEXT:  rd_addr = addr_q_r + AW'(1);
      default:  rd_addr = row_idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      first_q_r  <= first_mem_r[rd_addr];
      second_q_r <= second_mem_r[rd_addr];
      value_q_r  <= value_mem_r[rd_addr];
      addr_q_r   <= rd_addr;
    end
  end

  assign keep = ({2'b00, item_r.ignore_bits} >= WB7) ? '0 :
                ({WORD_BITS{1'b1}} << item_r.ignore_bits);

  assign match = (value_q_r != '0) && (first_q_r == k0w) &&
                 ((second_q_r & keep) == (k1w & keep));

  assign hit_word = (value_q_r & keep) | (k1w & ~keep);

  always_comb begin
    unique case (item_r.op)
      OP_RD_FIRST:  read_word = first_q_r;
      OP_RD_SECOND: read_word = second_q_r;
      OP_RD_VALUE:  read_word = value_q_r;
      default:      read_word = '0;
    endcase
  end

  always_comb begin
    result = '0;
    unique case (cmd.res_sel)
      RES_PLAIN: result.index_error = is_access && !in_range;
      RES_READ:  result.read_data = FIELD_BITS'(read_word);
      RES_HIT: begin
        result.read_data = FIELD_BITS'(hit_word);
        result.hit       = 1'b1;
      end
      default:   result = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign stat.is_lookup = (item_r.op == OP_LOOKUP);
  assign stat.is_read   = (item_r.op == OP_RD_FIRST) || (item_r.op == OP_RD_SECOND) ||
                          (item_r.op == OP_RD_VALUE);
  assign stat.in_range  = in_range;
  assign stat.match     = match;
  assign stat.scan_last = (addr_q_r == LAST_ROW);
  assign stat.clr_last  = (clr_r == LAST_ROW);
  assign stat.out_free  = !out_valid_r || out_ready;

endmodule

// ===== sv/masked_priority_cam.sv =====
// Channel   Ports                          Payload
// input     in_valid, in_ready, in_data    mcam_in_t
// result    out_valid, out_ready, out_data mcam_out_t
//
// After reset the three row stores are cleared, one row a cycle; in_ready stays low
// until that sweep is done.
// One transaction is processed at a time; a write or out-of-range access loads the result
// register from the DECODE state, and an in-range read from the READ state after DECODE.
// A lookup walks the single read port of the stores one row a cycle, from row 0, up to
// the first hit or, for a miss, through the last row.
// A stalled result holds its register; the next transaction may be accepted meanwhile,
// but it waits in its last cycle until the held result has been taken.
module masked_priority_cam
  import mcam_pkg::*;
#(
  parameter int ROWS      = 64,
  parameter int WORD_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  mcam_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output mcam_out_t out_data
);

  mcam_cmd_t  cmd;
  mcam_stat_t stat;

  mcam_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mcam_dp #(
    .ROWS      (ROWS),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
